FILE: hw/rtl/segi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segi_pkg: shared types and constants for the segment intersection pipeline
// Widths except TOL_W follow from COORD_W; payload structs for both channels.
// ----------------------------------------------------------------------------
package segi_pkg;

    // coordinate and derived arithmetic widths
    localparam int COORD_W = 24;
    localparam int DELTA_W = COORD_W + 1;
    localparam int PROD_W  = 2 * DELTA_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int CMP_W   = CROSS_W + 2;
    localparam int TOL_W   = 50;
    localparam int MAG_W   = CROSS_W;
    localparam int AMAG_W  = COORD_W;
    localparam int NUM_W   = MAG_W + AMAG_W;
    localparam int LO_W    = (MAG_W + 1) / 2;
    localparam int HI_W    = MAG_W - LO_W;
    localparam int PLO_W   = LO_W + AMAG_W;
    localparam int PHI_W   = HI_W + AMAG_W;
    localparam int DIV_LAT = AMAG_W;

    // status codes
    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_CROSS    = 2'd1;
    localparam logic [1:0] ST_PARALLEL = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [CROSS_W-1:0] cross_t;
    typedef logic signed [CMP_W-1:0]   cmp_t;

    typedef struct packed {
        coord_t ax_start;
        coord_t ay_start;
        coord_t ax_end;
        coord_t ay_end;
        coord_t bx_start;
        coord_t by_start;
        coord_t bx_end;
        coord_t by_end;
    } seg_in_t;

    typedef struct packed {
        logic [1:0] status;
        coord_t     cross_x;
        coord_t     cross_y;
    } seg_out_t;

    // front end results: box outcome, start point, A deltas, cross products
    typedef struct packed {
        logic   box_rej;
        coord_t x1;
        coord_t y1;
        delta_t ax;
        delta_t ay;
        cross_t d;
        cross_t e;
        cross_t f;
    } front_t;

    // sideband carried alongside the dividers
    typedef struct packed {
        logic [1:0] status;
        logic       neg_x;
        logic       neg_y;
        coord_t     x1;
        coord_t     y1;
    } side_t;

endpackage
`default_nettype wire

FILE: hw/rtl/segi_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segi_front: bounding box test, deltas, cross products
// Three register stages: deltas and box test, six products, d/e/f sums.
// ----------------------------------------------------------------------------
module segi_front import segi_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire seg_in_t in_data,
    output logic         out_valid,
    output front_t       out_data
);

    logic   a_valid_reg, b_valid_reg, c_valid_reg;
    logic   a_box_reg, b_box_reg;
    coord_t a_x1_reg, a_y1_reg, b_x1_reg, b_y1_reg;
    delta_t a_ax_reg, a_ay_reg, a_bx_reg, a_by_reg, a_cx_reg, a_cy_reg;
    delta_t b_ax_reg, b_ay_reg;
    prod_t  b_bycx_reg, b_bxcy_reg, b_aybx_reg, b_axby_reg, b_axcy_reg, b_aycx_reg;
    front_t c_data_reg;
    logic   box_next;

    // one-axis extent rejection
    function automatic logic box_rej(coord_t p1, coord_t p2, coord_t q1, coord_t q2);
        coord_t lo;
        coord_t hi;
        lo = (p2 < p1) ? p2 : p1;
        hi = (p2 < p1) ? p1 : p2;
        if (q1 > q2)
            return (hi < q2) || (q1 < lo);
        return (hi < q1) || (q2 < lo);
    endfunction

    assign box_next = box_rej(in_data.ax_start, in_data.ax_end, in_data.bx_start, in_data.bx_end)
                   || box_rej(in_data.ay_start, in_data.ay_end, in_data.by_start, in_data.by_end);

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_box_reg <= box_next;
            a_x1_reg  <= in_data.ax_start;
            a_y1_reg  <= in_data.ay_start;
            a_ax_reg  <= delta_t'(in_data.ax_end) - delta_t'(in_data.ax_start);
            a_ay_reg  <= delta_t'(in_data.ay_end) - delta_t'(in_data.ay_start);
            a_bx_reg  <= delta_t'(in_data.bx_start) - delta_t'(in_data.bx_end);
            a_by_reg  <= delta_t'(in_data.by_start) - delta_t'(in_data.by_end);
            a_cx_reg  <= delta_t'(in_data.ax_start) - delta_t'(in_data.bx_start);
            a_cy_reg  <= delta_t'(in_data.ay_start) - delta_t'(in_data.by_start);

            b_box_reg  <= a_box_reg;
            b_x1_reg   <= a_x1_reg;
            b_y1_reg   <= a_y1_reg;
            b_ax_reg   <= a_ax_reg;
            b_ay_reg   <= a_ay_reg;
            b_bycx_reg <= prod_t'(a_by_reg) * prod_t'(a_cx_reg);
            b_bxcy_reg <= prod_t'(a_bx_reg) * prod_t'(a_cy_reg);
            b_aybx_reg <= prod_t'(a_ay_reg) * prod_t'(a_bx_reg);
            b_axby_reg <= prod_t'(a_ax_reg) * prod_t'(a_by_reg);
            b_axcy_reg <= prod_t'(a_ax_reg) * prod_t'(a_cy_reg);
            b_aycx_reg <= prod_t'(a_ay_reg) * prod_t'(a_cx_reg);

            c_data_reg.box_rej <= b_box_reg;
            c_data_reg.x1      <= b_x1_reg;
            c_data_reg.y1      <= b_y1_reg;
            c_data_reg.ax      <= b_ax_reg;
            c_data_reg.ay      <= b_ay_reg;
            c_data_reg.d       <= cross_t'(b_bycx_reg) - cross_t'(b_bxcy_reg);
            c_data_reg.e       <= cross_t'(b_axcy_reg) - cross_t'(b_aycx_reg);
            c_data_reg.f       <= cross_t'(b_aybx_reg) - cross_t'(b_axby_reg);
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_data_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/segi_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segi_test: range tests, magnitudes and split products of d times delta
// Three register stages: status and magnitudes, partial products, numerators.
// ----------------------------------------------------------------------------
module segi_test import segi_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [TOL_W-1:0] tol,
    input  wire logic             in_valid,
    input  wire front_t           in_data,
    output logic                  out_valid,
    output side_t                 out_side,
    output logic [NUM_W-1:0]      num_x,
    output logic [NUM_W-1:0]      num_y,
    output logic [MAG_W-1:0]      den
);

    logic               s_valid_reg, p_valid_reg, n_valid_reg;
    side_t              s_side_reg, p_side_reg, n_side_reg;
    logic [MAG_W-1:0]   s_dmag_reg, s_fmag_reg, p_fmag_reg, n_fmag_reg;
    logic [AMAG_W-1:0]  s_axmag_reg, s_aymag_reg;
    logic [PLO_W-1:0]   p_xlo_reg, p_ylo_reg;
    logic [PHI_W-1:0]   p_xhi_reg, p_yhi_reg;
    logic [NUM_W-1:0]   n_numx_reg, n_numy_reg;
    logic [1:0]         status_next;
    logic               rej_d, rej_e;
    cmp_t               tn;
    cross_t             d_neg, f_neg;
    delta_t             ax_neg, ay_neg;

    // numerator against 0 and f with margin
    function automatic logic range_rej(cmp_t n, cmp_t f, cmp_t t);
        if (!f[CMP_W-1])
            return (n < t) || (n > (f - t));
        return (n > (-t)) || (n < (f + t));
    endfunction

    assign tn    = cmp_t'(tol);
    assign rej_d = range_rej(cmp_t'(in_data.d), cmp_t'(in_data.f), tn);
    assign rej_e = range_rej(cmp_t'(in_data.e), cmp_t'(in_data.f), tn);

    // status decision
    always_comb
    begin
        if (in_data.box_rej)
            status_next = ST_NONE;
        else if (in_data.f == '0)
            status_next = ST_PARALLEL;
        else if (rej_d || rej_e)
            status_next = ST_NONE;
        else
            status_next = ST_CROSS;
    end

    assign d_neg  = -in_data.d;
    assign f_neg  = -in_data.f;
    assign ax_neg = -in_data.ax;
    assign ay_neg = -in_data.ay;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            n_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s_valid_reg <= in_valid;
            p_valid_reg <= s_valid_reg;
            n_valid_reg <= p_valid_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_side_reg.status <= status_next;
            s_side_reg.neg_x  <= in_data.d[CROSS_W-1] ^ in_data.f[CROSS_W-1]
                               ^ in_data.ax[DELTA_W-1];
            s_side_reg.neg_y  <= in_data.d[CROSS_W-1] ^ in_data.f[CROSS_W-1]
                               ^ in_data.ay[DELTA_W-1];
            s_side_reg.x1     <= in_data.x1;
            s_side_reg.y1     <= in_data.y1;
            s_dmag_reg  <= in_data.d[CROSS_W-1] ? d_neg : in_data.d;
            s_fmag_reg  <= in_data.f[CROSS_W-1] ? f_neg : in_data.f;
            s_axmag_reg <= in_data.ax[DELTA_W-1] ? ax_neg[AMAG_W-1:0] : in_data.ax[AMAG_W-1:0];
            s_aymag_reg <= in_data.ay[DELTA_W-1] ? ay_neg[AMAG_W-1:0] : in_data.ay[AMAG_W-1:0];

            p_side_reg <= s_side_reg;
            p_fmag_reg <= s_fmag_reg;
            p_xlo_reg  <= PLO_W'(s_dmag_reg[LO_W-1:0]) * PLO_W'(s_axmag_reg);
            p_xhi_reg  <= PHI_W'(s_dmag_reg[MAG_W-1:LO_W]) * PHI_W'(s_axmag_reg);
            p_ylo_reg  <= PLO_W'(s_dmag_reg[LO_W-1:0]) * PLO_W'(s_aymag_reg);
            p_yhi_reg  <= PHI_W'(s_dmag_reg[MAG_W-1:LO_W]) * PHI_W'(s_aymag_reg);

            n_side_reg <= p_side_reg;
            n_fmag_reg <= p_fmag_reg;
            n_numx_reg <= NUM_W'(p_xlo_reg) + {p_xhi_reg, {LO_W{1'b0}}};
            n_numy_reg <= NUM_W'(p_ylo_reg) + {p_yhi_reg, {LO_W{1'b0}}};
        end
    end

    assign out_valid = n_valid_reg;
    assign out_side  = n_side_reg;
    assign num_x     = n_numx_reg;
    assign num_y     = n_numy_reg;
    assign den       = n_fmag_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/segi_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segi_div: pipelined restoring divider, one quotient bit per stage
// Unsigned magnitudes; quotient is known to fit in AMAG_W bits.
// ----------------------------------------------------------------------------
module segi_div import segi_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [MAG_W-1:0] den,
    output logic [AMAG_W-1:0]     quo
);

    logic [MAG_W-1:0]  rem_reg [DIV_LAT];
    logic [MAG_W-1:0]  den_reg [DIV_LAT];
    logic [AMAG_W-1:0] low_reg [DIV_LAT];
    logic [AMAG_W-1:0] quo_reg [DIV_LAT];

    for (genvar k = 0; k < DIV_LAT; k++)
    begin : g_stage
        logic [MAG_W-1:0]  rem_in;
        logic [MAG_W-1:0]  den_in;
        logic [AMAG_W-1:0] low_in;
        logic [AMAG_W-1:0] quo_in;
        logic [MAG_W:0]    trial;
        logic [MAG_W:0]    diff;
        logic              ge;

        // stage inputs
        if (k == 0)
        begin : g_first
            assign rem_in = num[NUM_W-1:AMAG_W];
            assign low_in = num[AMAG_W-1:0];
            assign quo_in = '0;
            assign den_in = den;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        // trial subtract
        assign trial = {rem_in, low_in[AMAG_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                low_reg[k] <= {low_in[AMAG_W-2:0], 1'b0};
                quo_reg[k] <= {quo_in[AMAG_W-2:0], ge};
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = quo_reg[DIV_LAT-1];

endmodule
`default_nettype wire

FILE: hw/rtl/segment_intersection.sv
`timescale 1ns / 1ps
`default_nettype none
// There are 31 register stages (3 front, 3 test, 24 divider, 1 output register);
// the pipeline takes one pair per cycle while no result is stalled.
// The divider length equals the coordinate width, one quotient bit a stage.
// The whole pipeline advances together; it holds while a result is stalled.
// Reset (rst_n, asynchronous) clears all valid bits and tolerance to zero.
// ----------------------------------------------------------------------------
// segment_intersection: streaming segment pair intersection test
// Box rejection, cross products, range test and crossing point division.
// ----------------------------------------------------------------------------
module segment_intersection import segi_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [TOL_W-1:0] cfg_wr_data,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire seg_in_t          in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output seg_out_t              out_data
);

    logic              en;
    logic [TOL_W-1:0]  tol_reg;
    logic              f_valid, t_valid;
    front_t            f_data;
    side_t             t_side;
    logic [NUM_W-1:0]  num_x, num_y;
    logic [MAG_W-1:0]  den;
    logic [AMAG_W-1:0] quo_x, quo_y;
    logic [DIV_LAT-1:0] dv_reg;
    side_t             side_reg [DIV_LAT];
    side_t             side_end;
    delta_t            qx, qy, sum_x, sum_y;
    logic              out_valid_reg;
    seg_out_t          out_data_reg;

    // pipeline advances unless a result is held
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (cfg_wr_en)
            tol_reg <= cfg_wr_data;
    end

    segi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_valid (f_valid),
        .out_data  (f_data)
    );

    segi_test u_test (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .tol       (tol_reg),
        .in_valid  (f_valid),
        .in_data   (f_data),
        .out_valid (t_valid),
        .out_side  (t_side),
        .num_x     (num_x),
        .num_y     (num_y),
        .den       (den)
    );

    segi_div u_div_x (
        .clk (clk),
        .en  (en),
        .num (num_x),
        .den (den),
        .quo (quo_x)
    );

    segi_div u_div_y (
        .clk (clk),
        .en  (en),
        .num (num_y),
        .den (den),
        .quo (quo_y)
    );

    // sideband delay matching the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg <= '0;
        else if (en)
            dv_reg <= {dv_reg[DIV_LAT-2:0], t_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= t_side;
            for (int i = 1; i < DIV_LAT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    assign side_end = side_reg[DIV_LAT-1];

    // signed quotient plus start point
    always_comb
    begin
        qx    = side_end.neg_x ? -delta_t'({1'b0, quo_x}) : delta_t'({1'b0, quo_x});
        qy    = side_end.neg_y ? -delta_t'({1'b0, quo_y}) : delta_t'({1'b0, quo_y});
        sum_x = delta_t'(side_end.x1) + qx;
        sum_y = delta_t'(side_end.y1) + qy;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_reg[DIV_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg.status <= side_end.status;
            if (side_end.status == ST_CROSS)
            begin
                out_data_reg.cross_x <= sum_x[COORD_W-1:0];
                out_data_reg.cross_y <= sum_y[COORD_W-1:0];
            end
            else
            begin
                out_data_reg.cross_x <= '0;
                out_data_reg.cross_y <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for segment_intersection
// Streams segment pairs through the pipeline with random gaps and stalls,
// predicts status and crossing point per pair, and compares every transfer.
// ----------------------------------------------------------------------------
module tb_top;
    import segi_pkg::*;

    localparam int PIPE_LAT  = 31;
    localparam int MAX_CYC   = 600000;
    localparam int N_RANDOM  = 700;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [TOL_W-1:0] cfg_wr_data;
    logic             in_valid;
    logic             in_stall;
    seg_in_t          in_data;
    logic             out_valid;
    logic             out_stall;
    seg_out_t         out_data;

    seg_in_t  pair_q[$];
    seg_out_t crossing_q[$];
    logic [TOL_W-1:0] margin;
    int n_err;
    int n_sent;
    int n_got;
    int n_cross;
    int n_par;
    int cycles;
    int gap_left;
    int stall_left;
    int hold_off;
    bit hold_req;

    segment_intersection dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // true when extents on one axis cannot overlap
    function automatic bit extent_apart(longint p1, longint p2, longint q1, longint q2);
        longint lo;
        longint hi;
        lo = (p2 < p1) ? p2 : p1;
        hi = (p2 < p1) ? p1 : p2;
        if (q1 > q2)
            return (hi < q2) || (q1 < lo);
        return (hi < q1) || (q2 < lo);
    endfunction

    // range test of a numerator against zero and f with the margin
    function automatic bit outside_span(logic signed [127:0] n, logic signed [127:0] f,
                                        logic signed [127:0] tol);
        if (f >= 0)
            return (n < tol) || (n > f - tol);
        return (n > -tol) || (n < f + tol);
    endfunction

    // expected status and crossing point of one pair
    function automatic seg_out_t crossing_of(seg_in_t p);
        seg_out_t r;
        logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
        logic signed [127:0] ax, ay, bx, by, cx, cy, d, e, f, tol, t;
        x1 = p.ax_start; y1 = p.ay_start; x2 = p.ax_end; y2 = p.ay_end;
        x3 = p.bx_start; y3 = p.by_start; x4 = p.bx_end; y4 = p.by_end;
        r = '0;
        r.status = ST_NONE;
        if (extent_apart(x1, x2, x3, x4) || extent_apart(y1, y2, y3, y4))
            return r;
        ax = x2 - x1; ay = y2 - y1; bx = x3 - x4; by = y3 - y4;
        cx = x1 - x3; cy = y1 - y3;
        d = by * cx - bx * cy;
        f = ay * bx - ax * by;
        if (f == 0)
        begin
            r.status = ST_PARALLEL;
            return r;
        end
        tol = $signed({78'd0, margin});
        if (outside_span(d, f, tol))
            return r;
        e = ax * cy - ay * cx;
        if (outside_span(e, f, tol))
            return r;
        r.status = ST_CROSS;
        t = x1 + (d * ax) / f;
        r.cross_x = t[COORD_W-1:0];
        t = y1 + (d * ay) / f;
        r.cross_y = t[COORD_W-1:0];
        return r;
    endfunction

    function automatic coord_t any_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'($urandom);
            1: return coord_t'(-8388608);
            2: return coord_t'(8388607);
            default: return coord_t'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    // pair built to cross often: B runs through a point on A
    function automatic seg_in_t likely_pair();
        seg_in_t p;
        int sc;
        coord_t mx, my;
        sc = ($urandom_range(0, 9) == 0) ? 4000000 : 3000;
        p.ax_start = coord_t'($signed($urandom_range(0, 2 * sc)) - sc);
        p.ay_start = coord_t'($signed($urandom_range(0, 2 * sc)) - sc);
        p.ax_end   = coord_t'($signed($urandom_range(0, 2 * sc)) - sc);
        p.ay_end   = coord_t'($signed($urandom_range(0, 2 * sc)) - sc);
        mx = coord_t'((p.ax_start + p.ax_end) >>> 1);
        my = coord_t'((p.ay_start + p.ay_end) >>> 1);
        p.bx_start = coord_t'(mx + $signed($urandom_range(0, 2 * sc)) - sc);
        p.by_start = coord_t'(my + $signed($urandom_range(0, 2 * sc)) - sc);
        p.bx_end   = coord_t'(2 * mx - p.bx_start);
        p.by_end   = coord_t'(2 * my - p.by_start);
        return p;
    endfunction

    function automatic seg_in_t mk(int a, int b, int c, int d, int e, int f, int g, int h);
        seg_in_t p;
        p.ax_start = coord_t'(a); p.ay_start = coord_t'(b);
        p.ax_end = coord_t'(c); p.ay_end = coord_t'(d);
        p.bx_start = coord_t'(e); p.by_start = coord_t'(f);
        p.bx_end = coord_t'(g); p.by_end = coord_t'(h);
        return p;
    endfunction

    task automatic wait_drained();
        while (pair_q.size() != 0 || crossing_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 5) @(posedge clk);
    endtask

    task automatic set_margin(logic [TOL_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        margin = v;
    endtask

    task automatic queue_directed();
        pair_q.push_back(mk(0, 0, 256, 256, 0, 256, 256, 0));
        pair_q.push_back(mk(0, 0, 256, 256, 512, 0, 768, 256));
        pair_q.push_back(mk(0, 0, 256, 0, 0, 512, 256, 768));
        pair_q.push_back(mk(0, 0, 256, 256, 128, 128, 384, 384));
        pair_q.push_back(mk(0, 0, 256, 0, 0, 256, 256, 256));
        pair_q.push_back(mk(0, 0, 256, 0, 256, 0, 256, 256));
        pair_q.push_back(mk(0, 0, 256, 0, 128, 0, 128, 256));
        pair_q.push_back(mk(-8388608, -8388608, 8388607, 8388607,
                            -8388608, 8388607, 8388607, -8388608));
        pair_q.push_back(mk(8388607, -8388608, -8388608, 8388607,
                            8388607, 8388607, -8388608, -8388608));
        pair_q.push_back(mk(-8388608, 0, 8388607, 0, 0, 8388607, 1, -8388608));
        pair_q.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1));
        pair_q.push_back(mk(5, 5, 5, 5, 0, 0, 10, 10));
        pair_q.push_back(mk(0, 0, 3, 7, 3, 0, 0, 7));
        pair_q.push_back(mk(100, -50, -100, 50, -3, -90, 7, 80));
        pair_q.push_back(mk(0, 0, 0, 256, -256, 128, 256, 128));
    endtask

    // stimulus and configuration phases
    initial
    begin
        logic [TOL_W-1:0] margins[5];
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        margin      = '0;
        hold_req    = 1'b0;
        n_err = 0; n_sent = 0; n_got = 0; n_cross = 0; n_par = 0;
        margins[0] = '0;
        margins[1] = 50'd1;
        margins[2] = 50'd40000;
        margins[3] = 50'd100000000;
        margins[4] = '1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        queue_directed();
        wait_drained();
        for (int ph = 0; ph < 5; ph++)
        begin
            set_margin(margins[ph]);
            if (ph == 1)
                queue_directed();
            if (ph == 2)
                hold_req = 1'b1;
            for (int i = 0; i < N_RANDOM / 5; i++)
            begin
                if ($urandom_range(0, 9) < 7)
                    pair_q.push_back(likely_pair());
                else
                    pair_q.push_back(mk(any_coord(), any_coord(), any_coord(), any_coord(),
                                        any_coord(), any_coord(), any_coord(), any_coord()));
            end
            wait_drained();
        end
        $display("covered %0d pairs, %0d results: %0d crossings, %0d parallel",
                 n_sent, n_got, n_cross, n_par);
        $display("margins from zero to full scale, with gaps, stalls and a long hold-off");
        if (n_err == 0)
            $display("** segment_intersection: PASSED **");
        else
            $display("** segment_intersection: FAILED **");
        $finish;
    end

    // sender: offers pairs from the queue with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                crossing_q.push_back(crossing_of(in_data));
                void'(pair_q.pop_front());
                n_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_valid && !in_stall && gap_left == 0 && $urandom_range(0, 3) == 0)
                    gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                          : $urandom_range(1, 3);
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pair_q.size() != 0 && !(in_valid && !in_stall && gap_left == 0
                                                 && 0))
                begin
                    in_valid <= 1'b1;
                    in_data  <= pair_q[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall: random, plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            hold_off   <= 0;
        end
        else if (hold_req && hold_off == 0)
        begin
            hold_off  <= 200;
            hold_req  <= 1'b0;
            out_stall <= 1'b1;
        end
        else if (hold_off > 1)
        begin
            hold_off  <= hold_off - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            hold_off   <= 0;
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else
        begin
            hold_off <= 0;
            case ($urandom_range(0, 15))
                0:       begin stall_left <= $urandom_range(5, 30); out_stall <= 1'b1; end
                1, 2, 3: begin stall_left <= $urandom_range(0, 2); out_stall <= 1'b1; end
                default: out_stall <= 1'b0;
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        seg_out_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            n_got++;
            if (crossing_q.size() == 0)
            begin
                $error("result transfer with nothing expected");
                n_err++;
            end
            else
            begin
                exp_r = crossing_q.pop_front();
                if (exp_r.status == ST_CROSS) n_cross++;
                if (exp_r.status == ST_PARALLEL) n_par++;
                if (out_data.status !== exp_r.status)
                begin
                    $error("status expected %0d got %0d", exp_r.status, out_data.status);
                    n_err++;
                end
                if (out_data.cross_x !== exp_r.cross_x)
                begin
                    $error("cross_x expected %0d got %0d", exp_r.cross_x, out_data.cross_x);
                    n_err++;
                end
                if (out_data.cross_y !== exp_r.cross_y)
                begin
                    $error("cross_y expected %0d got %0d", exp_r.cross_y, out_data.cross_y);
                    n_err++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYC)
        begin
            $display("** segment_intersection: FAILED **");
            $finish;
        end
    end

    initial cycles = 0;

endmodule
